>>> hw/rtl/b64d_pkg.sv
// shared types and constants of the base64 stream decoder
package b64d_pkg;

  // default depths of the two queues
  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam int unsigned RES_DEPTH_DEF = 2;

  // character classes
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  // symbol values of the alphabet sections
  localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
  localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SYM_62         = 6'd62;
  localparam logic [5:0] SYM_63         = 6'd63;

  // bit gathering
  localparam int unsigned BUF_W  = 12;
  localparam int unsigned PEND_W = 3;

  // result status codes
  localparam logic ST_BYTE  = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  typedef enum logic [1:0] {
    SK_DATA  = 2'd0,
    SK_PAD   = 2'd1,
    SK_SPACE = 2'd2,
    SK_BAD   = 2'd3
  } sym_kind_t;

  // classified item handed from front to back
  typedef struct packed {
    logic      start;
    sym_kind_t kind;
    logic [5:0] value;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       status;
    logic [7:0] data_byte;
  } res_t;

endpackage

>>> hw/rtl/base64_stream_decoder.sv
// top level of the base64 stream decoder
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+------------------
//  input   | in_char_code, in_start_of_text          | in        | in_push / in_full
//  result  | out_data_byte, out_status               | out       | out_pop / out_empty
//
// One character is taken per cycle while the item queue is not full. Any result of
// a character enters the result queue through the item queue and the bit-gathering
// stage, which waits while the result queue is full, and can be popped once stored.
// The back part stalls only when the result queue is full, and the front part
// only when the item queue is full. Reset is synchronous and empties both queues;
// it clears the bit buffer, the pending count and the padding and error flags.
module base64_stream_decoder #(
  parameter int unsigned CMD_DEPTH = b64d_pkg::CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = b64d_pkg::RES_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char_code,
  input  logic       in_start_of_text,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_data_byte,
  output logic       out_status
);
  import b64d_pkg::*;

  logic cmd_full, cmd_empty, cmd_push, cmd_pop;
  logic res_full, res_push;
  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;

  // classification
  b64d_front u_front (
    .in_push          (in_push),
    .in_char_code     (in_char_code),
    .in_start_of_text (in_start_of_text),
    .in_full          (in_full),
    .cmd_full         (cmd_full),
    .cmd_push         (cmd_push),
    .cmd              (cmd_in)
  );

  // item queue between front and back
  b64d_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // decoding
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue
  b64d_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_out),
    .empty   (out_empty)
  );

  assign out_data_byte = res_out.data_byte;
  assign out_status    = res_out.status;

endmodule

>>> hw/rtl/b64d_queue.sv
// small flip-flop queue used for the item and result queues of the decoder
module b64d_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/b64d_front.sv
// front part: takes characters, classifies them and queues them for the back part
module b64d_front (
  input  logic            in_push,
  input  logic [7:0]      in_char_code,
  input  logic            in_start_of_text,
  output logic            in_full,
  input  logic            cmd_full,
  output logic            cmd_push,
  output b64d_pkg::cmd_t  cmd
);
  import b64d_pkg::*;

  sym_kind_t  kind;
  logic [5:0] value;

  // alphabet lookup
  always_comb begin
    kind  = SK_BAD;
    value = '0;
    case (in_char_code) inside
      [CH_UPPER_A:CH_UPPER_Z]: begin
        kind  = SK_DATA;
        value = 6'(in_char_code - CH_UPPER_A);
      end
      [CH_LOWER_A:CH_LOWER_Z]: begin
        kind  = SK_DATA;
        value = 6'(in_char_code - CH_LOWER_A) + SYM_LOWER_BASE;
      end
      [CH_DIGIT_0:CH_DIGIT_9]: begin
        kind  = SK_DATA;
        value = 6'(in_char_code - CH_DIGIT_0) + SYM_DIGIT_BASE;
      end
      CH_PLUS, CH_MINUS: begin
        kind  = SK_DATA;
        value = SYM_62;
      end
      CH_SLASH, CH_UNDER: begin
        kind  = SK_DATA;
        value = SYM_63;
      end
      CH_EQUALS: kind = SK_PAD;
      CH_LF, CH_CR, CH_SPACE, CH_TAB: kind = SK_SPACE;
      default: kind = SK_BAD;
    endcase
  end

  // whitespace without a start marker changes nothing, so it is dropped here
  assign in_full   = cmd_full;
  assign cmd_push  = in_push && !cmd_full && !(kind == SK_SPACE && !in_start_of_text);
  assign cmd.start = in_start_of_text;
  assign cmd.kind  = kind;
  assign cmd.value = value;

endmodule

>>> hw/rtl/b64d_back.sv
// back part: bit gathering, padding and error tracking, one item per cycle while the result queue has room
module b64d_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_empty,
  input  b64d_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  input  logic            res_full,
  output logic            res_push,
  output b64d_pkg::res_t  res
);
  import b64d_pkg::*;

  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              pad_r, pad_nxt;
  logic              err_r, err_nxt;
  logic [BUF_W-1:0]  buf_cur;
  logic [PEND_W-1:0] pend_cur;
  logic              pad_cur;
  logic              err_cur;
  logic [PEND_W:0]   count;
  logic [BUF_W-1:0]  shifted;

  // the back part takes an item whenever one is waiting and the result queue has room
  assign cmd_pop = !cmd_empty && !res_full;

  // state as seen by this item, after an optional start marker
  always_comb begin
    buf_cur  = cmd.start ? '0 : buf_r;
    pend_cur = cmd.start ? '0 : pend_r;
    pad_cur  = cmd.start ? 1'b0 : pad_r;
    err_cur  = cmd.start ? 1'b0 : err_r;
  end

  // next state and result
  always_comb begin
    buf_nxt       = buf_cur;
    pend_nxt      = pend_cur;
    pad_nxt       = pad_cur;
    err_nxt       = err_cur;
    res_push      = 1'b0;
    res.status    = ST_BYTE;
    res.data_byte = '0;
    count         = {1'b0, pend_cur} + (PEND_W + 1)'(6);
    if (count >= (PEND_W + 1)'(8)) begin
      count = count - (PEND_W + 1)'(8);
    end
    shifted = '0;
    if (cmd_pop && !err_cur) begin
      case (cmd.kind)
        SK_BAD: begin
          err_nxt    = 1'b1;
          res_push   = 1'b1;
          res.status = ST_ERROR;
        end
        SK_PAD: begin
          pad_nxt  = 1'b1;
          buf_nxt  = {buf_cur[BUF_W-7:0], 6'd0};
          pend_nxt = count[PEND_W-1:0];
        end
        SK_DATA: begin
          if (pad_cur) begin
            err_nxt    = 1'b1;
            res_push   = 1'b1;
            res.status = ST_ERROR;
          end else begin
            buf_nxt  = {buf_cur[BUF_W-7:0], cmd.value};
            pend_nxt = count[PEND_W-1:0];
            shifted  = buf_nxt >> pend_nxt;
            if (pend_cur >= PEND_W'(2)) begin
              res_push      = 1'b1;
              res.data_byte = shifted[7:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      pend_r <= '0;
      pad_r  <= 1'b0;
      err_r  <= 1'b0;
    end else if (cmd_pop) begin
      buf_r  <= buf_nxt;
      pend_r <= pend_nxt;
      pad_r  <= pad_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

>>> hw/rtl/b64d_checker.sv
// port-level checks of the base64 stream decoder, bound to the top level
module b64d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_pop,
  input logic       out_empty,
  input logic [7:0] out_data_byte,
  input logic       out_status
);
  import b64d_pkg::*;

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // reset leaves room for input
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // an error result carries a zero byte
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_ERROR) |-> out_data_byte == 8'd0)
    else $error("error result with non-zero byte");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_data_byte) && $stable(out_status)))
    else $error("waiting result changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_pop       (out_pop),
  .out_empty     (out_empty),
  .out_data_byte (out_data_byte),
  .out_status    (out_status)
);

>>> test/b64d_checker.sv
// scoreboard for the base64 stream decoder: predicts every result item and compares it
module b64d_scoreboard (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_char_code,
  input  logic       in_start_of_text,
  input  logic       out_pop,
  input  logic       out_empty,
  input  logic [7:0] out_data_byte,
  input  logic       out_status,
  output int         fail_count,
  output int         results_owed,
  output int         live_chars,
  output int         bytes_seen,
  output int         errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  // shadow of the decoder state
  logic [BUF_W-1:0]  shadow_bits;
  logic [PEND_W-1:0] shadow_pend;
  logic              shadow_pad;
  logic              shadow_err;

  // decoded bytes and errors still to come out, oldest first
  res_t owed_q[$];

  int n_fail;
  int n_live;
  int n_bytes;
  int n_errors;

  initial begin
    n_fail   = 0;
    n_live   = 0;
    n_bytes  = 0;
    n_errors = 0;
  end

  // sort a raw character into its class and symbol value
  function automatic sym_kind_t char_class(input logic [7:0] ch, output logic [5:0] value);
    value = 6'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      value = 6'(ch - CH_UPPER_A);
      return SK_DATA;
    end
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      value = 6'(ch - CH_LOWER_A) + SYM_LOWER_BASE;
      return SK_DATA;
    end
    if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      value = 6'(ch - CH_DIGIT_0) + SYM_DIGIT_BASE;
      return SK_DATA;
    end
    if (ch == CH_PLUS || ch == CH_MINUS) begin
      value = SYM_62;
      return SK_DATA;
    end
    if (ch == CH_SLASH || ch == CH_UNDER) begin
      value = SYM_63;
      return SK_DATA;
    end
    if (ch == CH_EQUALS) return SK_PAD;
    if (ch == CH_LF || ch == CH_CR || ch == CH_SPACE || ch == CH_TAB) return SK_SPACE;
    return SK_BAD;
  endfunction

  function automatic void clear_shadow();
    shadow_bits = '0;
    shadow_pend = '0;
    shadow_pad  = 1'b0;
    shadow_err  = 1'b0;
  endfunction

  // advance the shadow state by one character and queue any result it causes
  function automatic void decode_char(input logic [7:0] ch, input logic sot);
    sym_kind_t  kind;
    logic [5:0] value;
    int         gathered;
    res_t       res;
    if (sot) clear_shadow();
    if (shadow_err) return;
    kind = char_class(ch, value);
    if (kind == SK_SPACE) return;
    n_live++;
    // bad character, or data once padding has started
    if (kind == SK_BAD || (kind == SK_DATA && shadow_pad)) begin
      shadow_err    = 1'b1;
      res.status    = ST_ERROR;
      res.data_byte = 8'h00;
      owed_q = {owed_q, res};
      return;
    end
    gathered = int'(shadow_pend) + 6;
    if (kind == SK_PAD) begin
      shadow_pad  = 1'b1;
      shadow_bits = {shadow_bits[5:0], 6'd0};
      shadow_pend = PEND_W'((gathered >= 8) ? gathered - 8 : gathered);
      return;
    end
    shadow_bits = {shadow_bits[5:0], value};
    if (gathered >= 8) begin
      shadow_pend   = PEND_W'(gathered - 8);
      res.status    = ST_BYTE;
      res.data_byte = 8'(shadow_bits >> shadow_pend);
      owed_q = {owed_q, res};
    end else begin
      shadow_pend = PEND_W'(gathered);
    end
  endfunction

  // compare results first, since a character taken at this edge cannot leave at it
  always @(posedge clk) begin
    res_t owed;
    if (!rst_n) begin
      clear_shadow();
      owed_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result item: status %0b data_byte 0x%02h", out_status,
                 out_data_byte);
          n_fail++;
        end else begin
          owed = owed_q.pop_front();
          if (out_status !== owed.status) begin
            $error("status mismatch: expected %0b actual %0b", owed.status, out_status);
            n_fail++;
          end
          if (out_data_byte !== owed.data_byte) begin
            $error("data_byte mismatch: expected 0x%02h actual 0x%02h", owed.data_byte,
                   out_data_byte);
            n_fail++;
          end
          if (owed.status == ST_ERROR) n_errors++;
          else n_bytes++;
        end
      end
      if (in_push && !in_full) decode_char(in_char_code, in_start_of_text);
    end
    fail_count   <= n_fail;
    results_owed <= owed_q.size();
    live_chars   <= n_live;
    bytes_seen   <= n_bytes;
    errors_seen  <= n_errors;
  end

endmodule

>>> test/testbench.sv
// top of the base64 stream decoder regression: clock, reset, character stimulus, verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  logic       clk;
  logic       rst_n            = 1'b0;
  logic       in_push          = 1'b0;
  logic [7:0] in_char_code     = 8'h00;
  logic       in_start_of_text = 1'b0;
  logic       in_full;
  logic       out_pop          = 1'b0;
  logic       out_empty;
  logic [7:0] out_data_byte;
  logic       out_status;

  int fail_count;
  int results_owed;
  int live_chars;
  int bytes_seen;
  int errors_seen;

  // idling odds in percent, and a request for a long receiver hold-off
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int full_stalls    = 0;
  int texts_sent     = 0;

  base64_stream_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_char_code     (in_char_code),
    .in_start_of_text (in_start_of_text),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_data_byte    (out_data_byte),
    .out_status       (out_status)
  );

  b64d_scoreboard u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_char_code     (in_char_code),
    .in_start_of_text (in_start_of_text),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_data_byte    (out_data_byte),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .results_owed     (results_owed),
    .live_chars       (live_chars),
    .bytes_seen       (bytes_seen),
    .errors_seen      (errors_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset held low at the start, then released once
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // receiver: random stalls, plus a long hold-off counted here when requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("base64_stream_decoder regression: fail");
    $finish;
  end

  // offer one character, with random idle cycles first, until it is taken
  task automatic offer_char(input logic [7:0] ch, input logic sot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_char_code     <= ch;
    in_start_of_text <= sot;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
  endtask

  // pause the sender until every owed result has come out
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // character for a six-bit symbol, in either alphabet
  function automatic logic [7:0] sym_char(input logic [5:0] v, input bit url);
    if (v < SYM_LOWER_BASE) return CH_UPPER_A + 8'(v);
    if (v < SYM_DIGIT_BASE) return CH_LOWER_A + 8'(v - SYM_LOWER_BASE);
    if (v < SYM_62) return CH_DIGIT_0 + 8'(v - SYM_DIGIT_BASE);
    if (v == SYM_62) return url ? CH_MINUS : CH_PLUS;
    return url ? CH_UNDER : CH_SLASH;
  endfunction

  // some character outside the alphabet, padding and whitespace
  function automatic logic [7:0] bad_char();
    string punct;
    punct = "!\"#$%&'(),.:;<>?@[\\]^`{|}~";
    case ($urandom_range(3))
      0: return 8'h80 | 8'($urandom_range(127));
      1: return 8'($urandom_range(8));
      2: return 8'h7F;
      default: return punct[$urandom_range(punct.len() - 1)];
    endcase
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(3))
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_SPACE;
      default: return CH_TAB;
    endcase
  endfunction

  // one text: well-formed, broken by a bad character or data after padding, or raw noise
  task automatic send_text(input int shape);
    int   n_data;
    int   n_pad;
    int   bad_at;
    int   bad_mode;
    int   i;
    logic sot;
    texts_sent++;
    if (shape == 2) begin
      n_data = $urandom_range(1, 10);
      for (i = 0; i < n_data; i++)
        offer_char(8'($urandom_range(255)), (i == 0) || ($urandom_range(15) == 0));
      return;
    end
    n_data   = $urandom_range(1, 24);
    n_pad    = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : (4 - n_data % 4) % 4;
    bad_mode = (shape == 1) ? $urandom_range(1) : -1;
    if (bad_mode == 1 && n_pad == 0) n_pad = 1;
    bad_at   = (bad_mode == 0) ? $urandom_range(0, n_data + n_pad - 1) : -1;
    // mostly a fresh text, sometimes carrying on with leftover bits
    sot      = ($urandom_range(9) != 0);
    for (i = 0; i < n_data + n_pad; i++) begin
      if ($urandom_range(7) == 0) begin
        offer_char(space_char(), sot);
        sot = 1'b0;
      end
      if (i == bad_at) offer_char(bad_char(), sot);
      else if (i < n_data) offer_char(sym_char(6'($urandom_range(63)), $urandom_range(1)), sot);
      else offer_char(CH_EQUALS, sot);
      sot = 1'b0;
    end
    // data after padding, possibly followed by more data that the latched error swallows
    if (bad_mode == 1) begin
      repeat ($urandom_range(1, 3))
        offer_char(sym_char(6'($urandom_range(63)), $urandom_range(1)), 1'b0);
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [8:0] opening [25];
    int         phase;
    int         goal;
    int         pick;
    opening = '{
      {1'b0, 8'h00},       {1'b0, CH_UPPER_A},  {1'b1, CH_UPPER_A},  {1'b0, CH_SLASH},
      {1'b0, CH_LF},       {1'b0, CH_CR},       {1'b0, CH_SPACE},    {1'b0, CH_TAB},
      {1'b0, CH_UNDER},    {1'b0, CH_PLUS},     {1'b0, CH_MINUS},    {1'b0, CH_UPPER_Z},
      {1'b0, CH_LOWER_A},  {1'b0, CH_LOWER_Z},  {1'b0, CH_DIGIT_0},  {1'b0, CH_DIGIT_9},
      {1'b0, CH_EQUALS},   {1'b0, CH_EQUALS},   {1'b0, CH_EQUALS},   {1'b0, CH_LOWER_A},
      {1'b0, CH_DIGIT_0},  {1'b1, 8'hFF},       {1'b1, CH_UPPER_Z},  {1'b0, 8'h80},
      {1'b1, CH_EQUALS}
    };
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed opening: alphabet ends, whitespace, padding, errors and the latch
    foreach (opening[i]) offer_char(opening[i][7:0], opening[i][8]);
    wait_drained();

    // random phases: no idling, sender idling, receiver stalling, both
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 13 : 0;
      recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 13 : 0;
      goal           = live_chars + 170;
      // long receiver hold-off while clean texts keep coming, to fill the block
      if (phase == 2) begin
        hold_request = 300;
        repeat (4) send_text(0);
      end
      while (live_chars < goal) begin
        pick = $urandom_range(99);
        send_text((pick < 70) ? 0 : (pick < 85) ? 1 : 2);
      end
      wait_drained();
    end

    // let anything still inside settle, with the receiver always ready
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("decoded %0d bytes and %0d error items from %0d texts (%0d characters acted on)",
             bytes_seen, errors_seen, texts_sent, live_chars);
    $display("input held off by a full block on %0d cycles", full_stalls);
    if (fail_count == 0) begin
      $display("base64_stream_decoder regression: pass");
    end else begin
      $display("base64_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
hw/rtl/b64d_checker.sv
test/b64d_checker.sv
test/testbench.sv
